// ===== src/utf8d_pkg.sv =====
// types and constants shared by the utf-8 decoder modules
`default_nettype none

package utf8d_pkg;

	localparam int CP_W = 21;

	localparam logic [CP_W-1:0] CP_REPLACEMENT = 21'h00fffd;
	localparam logic [CP_W-1:0] CP_MAX         = 21'h10ffff;

	localparam logic [7:0] LEAD4_MIN = 8'hf0;
	localparam logic [7:0] LEAD3_MIN = 8'he0;
	localparam logic [7:0] LEAD2_MIN = 8'hc0;
	localparam logic [1:0] CONT_TAG  = 2'b10;

	typedef struct packed {
		logic [7:0] byte_in;
		logic       string_end;
	} in_item_t;

	typedef struct packed {
		logic [CP_W-1:0] code_point;
		logic            run_last;
		logic            string_done;
	} out_item_t;

	// all results caused by one input byte
	typedef struct packed {
		logic      dual;
		out_item_t r0;
		out_item_t r1;
	} entry_t;

endpackage

`default_nettype wire

// ===== src/utf8d_front.sv =====
// front part: accepts bytes, tracks the open sequence and forms result entries
`default_nettype none

module utf8d_front import utf8d_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     accept,
	input  wire in_item_t item,
	output logic          wr,
	output entry_t        wr_entry
);

	logic [1:0]      pend_q;
	logic [CP_W-1:0] part_q;

	logic [1:0]      pend_d;
	logic [CP_W-1:0] part_d;
	logic [1:0]      n;
	logic [CP_W-1:0] cp0;
	logic [CP_W-1:0] cp1;
	logic [CP_W-1:0] merged;
	logic            as_lead;
	logic [7:0]      b;

	always_comb begin
		b       = item.byte_in;
		pend_d  = pend_q;
		part_d  = part_q;
		n       = 2'd0;
		cp0     = CP_REPLACEMENT;
		cp1     = CP_REPLACEMENT;
		as_lead = 1'b1;
		merged  = {part_q[CP_W-7:0], b[5:0]};

		if (pend_q != 2'd0) begin
			if (b[7:6] == CONT_TAG) begin
				as_lead = 1'b0;
				part_d  = merged;
				pend_d  = pend_q - 2'd1;
				if (pend_d == 2'd0) begin
					cp0    = (merged > CP_MAX) ? CP_REPLACEMENT : merged;
					n      = 2'd1;
					part_d = '0;
				end
			end else begin
				// missing continuation, byte then taken again as a lead
				cp0    = CP_REPLACEMENT;
				n      = 2'd1;
				pend_d = 2'd0;
				part_d = '0;
			end
		end

		if (as_lead) begin
			priority if (b >= LEAD4_MIN) begin
				part_d = CP_W'(b[2:0]);
				pend_d = 2'd3;
			end else if (b >= LEAD3_MIN) begin
				part_d = CP_W'(b[3:0]);
				pend_d = 2'd2;
			end else if (b >= LEAD2_MIN) begin
				part_d = CP_W'(b[4:0]);
				pend_d = 2'd1;
			end else begin
				if (n == 2'd0) cp0 = CP_W'(b);
				else cp1 = CP_W'(b);
				n = n + 2'd1;
			end
		end

		if (item.string_end) begin
			if (pend_d != 2'd0) begin
				if (n == 2'd0) cp0 = CP_REPLACEMENT;
				else cp1 = CP_REPLACEMENT;
				n = n + 2'd1;
			end
			pend_d = 2'd0;
			part_d = '0;
		end
	end

	always_comb begin
		wr                     = accept && (n != 2'd0);
		wr_entry.dual          = (n == 2'd2);
		wr_entry.r0.code_point = cp0;
		wr_entry.r0.run_last   = (n != 2'd2);
		wr_entry.r0.string_done = (n != 2'd2) && item.string_end;
		wr_entry.r1.code_point = cp1;
		wr_entry.r1.run_last   = 1'b1;
		wr_entry.r1.string_done = item.string_end;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 2'd0;
			part_q <= '0;
		end else if (accept) begin
			pend_q <= pend_d;
			part_q <= part_d;
		end
	end

endmodule

`default_nettype wire

// ===== src/utf8d_queue.sv =====
// small entry queue between the front and back parts
`default_nettype none

module utf8d_queue import utf8d_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   wr,
	input  wire entry_t wr_entry,
	input  wire logic   rd,
	output entry_t      rd_entry,
	output logic        q_empty,
	output logic        q_full
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	entry_t        mem_q [DEPTH];
	logic [PW-1:0] wptr_q;
	logic [PW-1:0] rptr_q;
	logic [CW-1:0] count_q;

	function automatic logic [PW-1:0] ptr_next(input logic [PW-1:0] p);
		ptr_next = (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
	endfunction

	assign rd_entry = mem_q[rptr_q];
	assign q_empty  = (count_q == '0);
	assign q_full   = (count_q == CW'(DEPTH));

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (wr) wptr_q <= ptr_next(wptr_q);
			if (rd) rptr_q <= ptr_next(rptr_q);
			if (wr && !rd) count_q <= count_q + CW'(1);
			else if (rd && !wr) count_q <= count_q - CW'(1);
		end
	end

endmodule

`default_nettype wire

// ===== src/utf8d_back.sv =====
// back part: splits entries into single results and holds the output register
`default_nettype none

module utf8d_back import utf8d_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   q_empty,
	input  wire entry_t rd_entry,
	output logic        rd,
	input  wire logic   pop,
	output logic        empty,
	output out_item_t   result
);

	logic      sel_q;
	logic      out_valid_q;
	out_item_t out_q;
	logic      load;
	out_item_t cur;

	assign cur    = sel_q ? rd_entry.r1 : rd_entry.r0;
	assign load   = !q_empty && (!out_valid_q || pop);
	assign rd     = load && (sel_q == rd_entry.dual);
	assign empty  = !out_valid_q;
	assign result = out_q;

	always_ff @(posedge clk) begin
		if (load) out_q <= cur;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				sel_q       <= rd ? 1'b0 : 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

// ===== src/utf8_to_code_point_decoder.sv =====
// top level of the lenient utf-8 to code point decoder
//
// input side is a queue: drive item and push, a transaction happens at a
// clock edge with push high and full low. one byte per transaction, with
// string_end marking the final byte of a string.
// output side is a queue: while empty is low the oldest code point sits on
// result; a transaction happens at an edge with pop high and empty low.
// each byte causes zero, one or two results; run_last flags the last one
// of a byte and string_done the last one of a string.
// a byte can be taken every cycle while full is low; the front decodes it
// in the accept cycle and writes an entry into a DEPTH-entry queue. the
// back unloads one result per cycle into the output register while it is
// empty or popped, so the first result of a byte passes the queue and then
// the output register before it can be popped. bytes giving two results are
// unloaded one at a time, which sets the sustained rate when they repeat.
// when the receiver stalls the queue fills and full rises; nothing is lost.
// reset clears the open sequence, the queue and the output register.
`default_nettype none

module utf8_to_code_point_decoder import utf8d_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     push,
	output logic          full,
	input  wire in_item_t item,
	output logic          empty,
	input  wire logic     pop,
	output out_item_t     result
);

	logic   accept;
	logic   wr;
	entry_t wr_entry;
	logic   rd;
	entry_t rd_entry;
	logic   q_empty;
	logic   q_full;

	assign full   = q_full;
	assign accept = push && !q_full;

	utf8d_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.item     (item),
		.wr       (wr),
		.wr_entry (wr_entry)
	);

	utf8d_queue #(
		.DEPTH (DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (wr),
		.wr_entry (wr_entry),
		.rd       (rd),
		.rd_entry (rd_entry),
		.q_empty  (q_empty),
		.q_full   (q_full)
	);

	utf8d_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (q_empty),
		.rd_entry (rd_entry),
		.rd       (rd),
		.pop      (pop),
		.empty    (empty),
		.result   (result)
	);

endmodule

`default_nettype wire
